[hw/rtl/grrle_pkg.sv]
// grrle_pkg: shared types and constants for the raster row decoder
// no dependencies
`timescale 1ns / 1ps

package grrle_pkg;

  // line store geometry
  localparam int MAX_PLANE_BYTES = 256;
  localparam int MAX_PLANES      = 8;
  localparam int MAX_PATTERN     = 16;
  localparam int LINE_SIZE       = MAX_PLANE_BYTES * MAX_PLANES;

  localparam logic [1:0] MODE_FEED    = 2'd0;
  localparam logic [1:0] MODE_READ    = 2'd1;
  localparam logic [1:0] MODE_RESTART = 2'd2;
  localparam logic [1:0] MODE_NOP     = 2'd3;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_FLAG     = 3'd1;
  localparam logic [2:0] ERR_REPEAT   = 3'd2;
  localparam logic [2:0] ERR_ZERO_REP = 3'd3;
  localparam logic [2:0] ERR_OVERRUN  = 3'd4;

  localparam logic [7:0] BYTE_LITERAL = 8'h80;
  localparam logic [7:0] BYTE_FLAG    = 8'hff;
  localparam logic [7:0] RUN_MASK     = 8'h7f;
  localparam int         OVERRUN_SLACK = 4;
  localparam int         PROD_MAX     = 8191;

  localparam logic [1:0] REG_ROW_BYTES = 2'd0;
  localparam logic [1:0] REG_PLANES    = 2'd1;
  localparam logic [1:0] REG_PAT_LEN   = 2'd2;
  localparam logic [1:0] REG_HEIGHT    = 2'd3;

  typedef enum logic [1:0] {
    PH_DECODE = 2'd0,
    PH_EMIT   = 2'd1,
    PH_DONE   = 2'd2,
    PH_ERROR  = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    OP_AWAIT    = 3'd0,
    OP_SECOND   = 3'd1,
    OP_FLAG     = 3'd2,
    OP_REPCOUNT = 3'd3,
    OP_LITCOUNT = 3'd4,
    OP_LITERAL  = 3'd5,
    OP_PATTERN  = 3'd6
  } op_t;

  // one-hot sequencer states of the top-level control
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_FILL  = 6'b000010,
    S_PFETCH= 6'b000100,
    S_RDWAIT= 6'b001000,
    S_OUT   = 6'b010000,
    S_FIN   = 6'b100000
  } seq_t;

endpackage

[hw/rtl/gem_raster_rle_row_decoder.sv]
// gem_raster_rle_row_decoder: top level, opcode decode and run sequencer
// depends on grrle_pkg, grrle_cfg, grrle_line_mem
//
// channel   dir  handshake            payload
// s_axis    in   tvalid/tready        tdata {data_byte, mode}
// m_axis    out  tvalid/tready        tdata {err, last_img, last_row, valid, byte, acc}
// apb       in   psel/penable/pwrite  four registers at 4*i
//
// one item is taken at a time. a control byte is decoded, then its result goes
// to the output transfer. a solid run writes the line store one byte per cycle;
// a pattern run expands each byte by a pattern store read, then a write. a read
// takes a line store read, then the output. reset is synchronous and clears all
// control; the line and pattern stores are not cleared. s_tready is low while
// an item is in work or its result is not taken.
`timescale 1ns / 1ps

module gem_raster_rle_row_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [1:0] mode, [9:2] data_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [0] accepted, [8:1] out_byte, [9] out_valid,
                                 // [10] last_of_row, [11] last_of_image, [14:12] error_code
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int LINE = grrle_pkg::LINE_SIZE;
  localparam int AW   = (LINE > 1) ? $clog2(LINE) : 1;
  localparam int PW   = (grrle_pkg::MAX_PATTERN > 1) ? $clog2(grrle_pkg::MAX_PATTERN) : 1;

  logic [8:0]  r_rb;
  logic [3:0]  r_pc;
  logic [4:0]  r_pl;
  logic [15:0] r_h;

  grrle_cfg u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .plane_row_bytes(r_rb), .plane_count(r_pc), .pattern_length(r_pl),
    .image_height(r_h)
  );

  // effective register values
  logic [13:0] rb;
  logic [3:0]  pc;
  logic [4:0]  pl;
  logic [15:0] eh;
  always_comb begin
    rb = (r_rb == 9'd0) ? 14'd1 :
         ({5'd0, r_rb} > 14'(grrle_pkg::MAX_PLANE_BYTES)) ?
         14'(grrle_pkg::MAX_PLANE_BYTES) : {5'd0, r_rb};
    pc = (r_pc == 4'd0) ? 4'd1 :
         (r_pc > 4'(grrle_pkg::MAX_PLANES)) ? 4'(grrle_pkg::MAX_PLANES) : r_pc;
    pl = (r_pl == 5'd0) ? 5'd1 :
         (r_pl > 5'(grrle_pkg::MAX_PATTERN)) ? 5'(grrle_pkg::MAX_PATTERN) : r_pl;
    eh = (r_h == 16'd0) ? 16'd1 : r_h;
  end

  grrle_pkg::seq_t   seq;
  grrle_pkg::phase_t phase;
  grrle_pkg::op_t    op;
  logic [PW-1:0]  pat_idx;
  logic [7:0]     run_rem;
  logic [12:0]    produced;
  logic [2:0]     plane;
  logic           first_op;
  logic [7:0]     rep_total, rep_done;
  logic [15:0]    row_num;
  logic [10:0]    emit_idx;
  logic [2:0]     err;
  logic [7:0]     pat_mem [grrle_pkg::MAX_PATTERN];

  // expansion state
  logic [7:0]     fill_val;
  logic           fill_pat;
  logic [7:0]     fill_cnt;    // remaining pattern repeats or solid bytes
  logic [PW-1:0]  fill_pi;
  logic [7:0]     pat_rd;

  // output holding register
  logic [14:0]    res;

  // base address of plane in line store: plane * rb (narrow multiply)
  logic [AW-1:0]  base;
  assign base = AW'(({11'd0, plane} & 14'd7) * rb);

  // line store
  logic           mwe;
  logic [AW-1:0]  mwa, mra;
  logic [7:0]     mwd, mrd;
  grrle_line_mem #(.DEPTH(LINE), .AW(AW)) u_mem (
    .clk, .we(mwe), .waddr(mwa), .wdata(mwd), .raddr(mra), .rdata(mrd)
  );

  logic [1:0] in_mode;
  logic [7:0] in_b;
  assign in_mode  = s_tdata[1:0];
  assign in_b     = s_tdata[9:2];
  assign s_tready = (seq == grrle_pkg::S_IDLE) && !m_tvalid;

  logic [7:0] put_val;
  logic       putting;
  always_comb begin
    put_val = fill_pat ? pat_rd : fill_val;
    putting = (seq == grrle_pkg::S_FILL) && (fill_cnt != 8'd0);
    mwe = 1'b0;
    mwa = base + AW'(produced);
    mwd = put_val;
    if (putting && ({1'b0, produced} < rb)) mwe = 1'b1;
    if ((seq == grrle_pkg::S_IDLE) && s_tvalid && !m_tvalid &&
        in_mode == grrle_pkg::MODE_FEED && phase == grrle_pkg::PH_DECODE &&
        op == grrle_pkg::OP_LITERAL && ({1'b0, produced} < rb)) begin
      mwe = 1'b1;
      mwd = in_b;
    end
    mra = emit_idx[AW-1:0];
  end

  logic [13:0] total;
  assign total = rb * {10'd0, pc};

  // end of opcode handling, evaluated with a given produced count
  task automatic end_op(input logic [12:0] prod);
    op <= grrle_pkg::OP_AWAIT;
    if ({1'b0, prod} < rb) begin
      produced <= prod;
      first_op <= 1'b0;
    end else if ({1'b0, prod} > rb + 14'(grrle_pkg::OVERRUN_SLACK)) begin
      produced <= prod;
      first_op <= 1'b0;
      err      <= grrle_pkg::ERR_OVERRUN;
      phase    <= grrle_pkg::PH_ERROR;
    end else if ({1'b0, plane} + 4'd1 >= pc) begin
      produced <= prod;
      first_op <= 1'b0;
      phase    <= grrle_pkg::PH_EMIT;
      emit_idx <= '0;
      rep_done <= '0;
    end else begin
      plane    <= plane + 3'd1;
      produced <= '0;
      first_op <= 1'b1;
    end
  endtask

  task automatic new_row();
    phase     <= grrle_pkg::PH_DECODE;
    op        <= grrle_pkg::OP_AWAIT;
    plane     <= '0;
    produced  <= '0;
    first_op  <= 1'b1;
    rep_total <= 8'd1;
    pat_idx   <= '0;
    run_rem   <= '0;
  endtask

  always_ff @(posedge clk) begin
    if (seq == grrle_pkg::S_IDLE && s_tvalid && !m_tvalid &&
        in_mode == grrle_pkg::MODE_FEED && phase == grrle_pkg::PH_DECODE &&
        op == grrle_pkg::OP_PATTERN)
      pat_mem[pat_idx] <= in_b;
    pat_rd <= pat_mem[fill_pi];
  end

  logic [12:0] prod_inc;
  assign prod_inc = (produced < 13'(grrle_pkg::PROD_MAX)) ? produced + 13'd1 : produced;

  always_ff @(posedge clk) begin
    if (rst) begin
      seq <= grrle_pkg::S_IDLE;
      new_row();
      rep_done <= '0; row_num <= '0; emit_idx <= '0; err <= grrle_pkg::ERR_NONE;
      m_tvalid <= 1'b0;
      fill_cnt <= '0; fill_pat <= 1'b0; fill_pi <= '0; fill_val <= '0;
      res <= '0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      unique case (seq)
        grrle_pkg::S_IDLE: begin
          if (s_tvalid && s_tready) begin
            res <= {14'd0, (in_mode == grrle_pkg::MODE_FEED) &&
                           (phase == grrle_pkg::PH_DECODE)};
            unique case (in_mode)
              grrle_pkg::MODE_FEED: begin
                if (phase == grrle_pkg::PH_DECODE) begin
                  unique case (op)
                    grrle_pkg::OP_SECOND: begin
                      if (in_b != 8'd0) begin
                        run_rem <= in_b; pat_idx <= '0; op <= grrle_pkg::OP_PATTERN;
                      end else op <= grrle_pkg::OP_FLAG;
                      seq <= grrle_pkg::S_FIN;
                    end
                    grrle_pkg::OP_FLAG: begin
                      if (in_b != grrle_pkg::BYTE_FLAG) begin
                        err <= grrle_pkg::ERR_FLAG; phase <= grrle_pkg::PH_ERROR;
                      end else if (!(first_op && plane == 3'd0)) begin
                        err <= grrle_pkg::ERR_REPEAT; phase <= grrle_pkg::PH_ERROR;
                      end else op <= grrle_pkg::OP_REPCOUNT;
                      seq <= grrle_pkg::S_FIN;
                    end
                    grrle_pkg::OP_REPCOUNT: begin
                      if (in_b == 8'd0) begin
                        err <= grrle_pkg::ERR_ZERO_REP; phase <= grrle_pkg::PH_ERROR;
                      end else begin
                        rep_total <= in_b;
                        end_op(produced);
                      end
                      seq <= grrle_pkg::S_FIN;
                    end
                    grrle_pkg::OP_LITCOUNT: begin
                      run_rem <= in_b;
                      if (in_b == 8'd0) end_op(produced);
                      else op <= grrle_pkg::OP_LITERAL;
                      seq <= grrle_pkg::S_FIN;
                    end
                    grrle_pkg::OP_LITERAL: begin
                      run_rem <= run_rem - 8'd1;
                      if (run_rem == 8'd1) end_op(prod_inc);
                      else produced <= prod_inc;
                      seq <= grrle_pkg::S_FIN;
                    end
                    grrle_pkg::OP_PATTERN: begin
                      if ({1'b0, pat_idx} + 5'd1 >= pl) begin
                        pat_idx  <= '0;
                        fill_pat <= 1'b1;
                        fill_cnt <= run_rem;
                        fill_pi  <= '0;
                        seq      <= grrle_pkg::S_PFETCH;
                      end else begin
                        pat_idx <= pat_idx + PW'(1);
                        seq     <= grrle_pkg::S_FIN;
                      end
                    end
                    default: begin
                      if (in_b == 8'd0) begin
                        op  <= grrle_pkg::OP_SECOND;
                        seq <= grrle_pkg::S_FIN;
                      end else if (in_b == grrle_pkg::BYTE_LITERAL) begin
                        op  <= grrle_pkg::OP_LITCOUNT;
                        seq <= grrle_pkg::S_FIN;
                      end else begin
                        fill_pat <= 1'b0;
                        fill_val <= in_b[7] ? 8'hff : 8'h00;
                        fill_cnt <= in_b & grrle_pkg::RUN_MASK;
                        seq      <= grrle_pkg::S_FILL;
                      end
                    end
                  endcase
                end else seq <= grrle_pkg::S_FIN;
              end
              grrle_pkg::MODE_READ: begin
                if (phase == grrle_pkg::PH_EMIT) seq <= grrle_pkg::S_RDWAIT;
                else seq <= grrle_pkg::S_FIN;
              end
              grrle_pkg::MODE_RESTART: begin
                new_row();
                rep_done <= '0; row_num <= '0; emit_idx <= '0;
                err <= grrle_pkg::ERR_NONE;
                seq <= grrle_pkg::S_FIN;
              end
              default: seq <= grrle_pkg::S_FIN;
            endcase
          end
        end
        grrle_pkg::S_PFETCH: seq <= grrle_pkg::S_FILL;  // pattern read latency
        grrle_pkg::S_FILL: begin
          if (fill_cnt == 8'd0) begin
            end_op(produced);
            seq <= grrle_pkg::S_FIN;
          end else begin
            produced <= prod_inc;
            if (fill_pat) begin
              if ({1'b0, fill_pi} + 5'd1 >= pl) begin
                fill_pi  <= '0;
                fill_cnt <= fill_cnt - 8'd1;
              end else fill_pi <= fill_pi + PW'(1);
              seq <= grrle_pkg::S_PFETCH;
            end else fill_cnt <= fill_cnt - 8'd1;
          end
        end
        grrle_pkg::S_RDWAIT: seq <= grrle_pkg::S_OUT;
        grrle_pkg::S_OUT: begin
          res[8:1] <= mrd;
          res[9]   <= 1'b1;
          if ({3'd0, emit_idx} + 14'd1 >= total) begin
            res[10]  <= 1'b1;
            emit_idx <= '0;
            row_num  <= row_num + 16'd1;
            rep_done <= rep_done + 8'd1;
            if (row_num + 16'd1 >= eh) begin
              res[11] <= 1'b1;
              phase   <= grrle_pkg::PH_DONE;
            end else if (rep_done + 8'd1 >= rep_total) new_row();
          end else emit_idx <= emit_idx + 11'd1;
          seq <= grrle_pkg::S_FIN;
        end
        grrle_pkg::S_FIN: begin
          res[14:12] <= err;
          m_tvalid   <= 1'b1;
          seq        <= grrle_pkg::S_IDLE;
        end
        default: seq <= grrle_pkg::S_IDLE;
      endcase
    end
  end

  assign m_tdata = {1'b0, res};

endmodule

[hw/rtl/grrle_cfg.sv]
// grrle_cfg: apb register file holding the four configuration registers
// depends on grrle_pkg
`timescale 1ns / 1ps

module grrle_cfg (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [8:0]  plane_row_bytes,
  output logic [3:0]  plane_count,
  output logic [4:0]  pattern_length,
  output logic [15:0] image_height
);

  logic [1:0] idx;
  logic       wr;
  assign idx    = paddr[3:2];
  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      plane_row_bytes <= 9'd1;
      plane_count     <= 4'd1;
      pattern_length  <= 5'd2;
      image_height    <= 16'd1;
    end else if (wr) begin
      unique case (idx)
        grrle_pkg::REG_ROW_BYTES: plane_row_bytes <= pwdata[8:0];
        grrle_pkg::REG_PLANES:    plane_count     <= pwdata[3:0];
        grrle_pkg::REG_PAT_LEN:   pattern_length  <= pwdata[4:0];
        grrle_pkg::REG_HEIGHT:    image_height    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      grrle_pkg::REG_ROW_BYTES: prdata = {23'd0, plane_row_bytes};
      grrle_pkg::REG_PLANES:    prdata = {28'd0, plane_count};
      grrle_pkg::REG_PAT_LEN:   prdata = {27'd0, pattern_length};
      grrle_pkg::REG_HEIGHT:    prdata = {16'd0, image_height};
      default:                  prdata = 32'd0;
    endcase
  end

endmodule

[hw/rtl/grrle_line_mem.sv]
// grrle_line_mem: single-port-write, registered-read line store
// no package dependencies
`timescale 1ns / 1ps

module grrle_line_mem #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule
